// ===== src/mmos_pkg.sv =====
// ---------------------------------------------------------------------------
// mmos_pkg: shared types and constants for the memory map sanitizer
// Entry and region transaction structs, cell payload, status codes.
// ---------------------------------------------------------------------------
package mmos_pkg;

  localparam int MaxEntries = 32;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int NumPts     = 2 * MaxEntries;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FEW  = 2'd1;
  localparam logic [1:0] STATUS_WRAP = 2'd2;

  typedef struct packed {
    logic [63:0] entry_start;
    logic [63:0] entry_size;
    logic [31:0] entry_type;
    logic        last_entry;
  } mmos_in_t;

  typedef struct packed {
    logic [63:0] region_start;
    logic [63:0] region_size;
    logic [31:0] region_type;
    logic [1:0]  status;
    logic        map_empty;
    logic        overflowed;
    logic        last_region;
  } mmos_out_t;

  // One sort point: address, end flag, entry index, valid.
  typedef struct packed {
    logic            vld;
    logic [63:0]     addr;
    logic            is_end;
    logic [IdxW-1:0] idx;
  } mmos_pt_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_RAW,
    ST_FILL,
    ST_DRAIN,
    ST_SWEEP,
    ST_EMPTY
  } mmos_state_t;

  // a goes before b
  function automatic logic pt_before(mmos_pt_t a, mmos_pt_t b);
    if (!b.vld) return a.vld;
    if (!a.vld) return 1'b0;
    if (a.addr < b.addr) return 1'b1;
    return (a.addr == b.addr) && !a.is_end && b.is_end;
  endfunction

endpackage

// ===== src/memory_map_overlap_sanitizer.sv =====
// ---------------------------------------------------------------------------
// memory_map_overlap_sanitizer: e820-style memory map sanitizer
// Loads entries, sorts their boundary points in a cell row, sweeps regions.
// ---------------------------------------------------------------------------
// Input: hold start high with in_data; a transaction is taken at the edge
// where start is high and busy low. Entries load one per cycle, no gap.
// The transaction with last_entry set begins processing and busy stays high
// until the cycle in which the final result is driven. With N stored entries:
// Check: under two entries, no wrap detection; else all N are checked for wrap.
// Unchanged map: one result per cycle; an empty map goes to its marker
// through the empty state.
// Sanitized map: the fill state feeds start points, then end points, of the
// nonempty entries; the drain state lets the row settle; then each sorted
// point is popped from cell zero, the open types are scanned over all
// MaxEntries slots, and a decide step follows. One region is held back so the
// final one carries last_region; it leaves after the last point is decided.
// Results are registered and shown on out_valid for one cycle each; the
// receiver cannot stall. Reset clears the entry count, overflow flag,
// sorter and controller; entry storage is not cleared.
// ---------------------------------------------------------------------------
module memory_map_overlap_sanitizer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  mmos_pkg::mmos_in_t   in_data,
  output logic                 out_valid,
  output mmos_pkg::mmos_out_t  out_data
);
  import mmos_pkg::*;

  localparam logic [CntW:0] SettleLast = (CntW+1)'(NumPts);

  logic [63:0] st_mem [MaxEntries];
  logic [63:0] sz_mem [MaxEntries];
  logic [31:0] ty_mem [MaxEntries];

  mmos_state_t state_r, state_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic ovf_r, ovf_nxt;
  logic [1:0] stat_r, stat_nxt;
  logic [CntW:0] ptr_r, ptr_nxt;
  logic [CntW:0] wait_r, wait_nxt;
  logic [CntW:0] npts_r, npts_nxt;
  logic [MaxEntries-1:0] open_r, open_nxt;
  logic [31:0] last_ty_r, last_ty_nxt;
  logic [63:0] prev_addr_r, prev_addr_nxt, reg_st_r, reg_st_nxt;
  logic [31:0] reg_ty_r, reg_ty_nxt;
  logic [63:0] pend_st_r, pend_st_nxt, pend_sz_r, pend_sz_nxt;
  logic [31:0] pend_ty_r, pend_ty_nxt;
  logic [CntW-1:0] nreg_r, nreg_nxt;
  logic [IdxW:0] scan_r, scan_nxt;
  logic [31:0] cur_r, cur_nxt;
  mmos_pt_t pt_r, pt_nxt;
  logic scanning_r, scanning_nxt;

  logic accept, srt_clr, srt_drain, srt_ins;
  mmos_pt_t srt_in, head;
  logic [63:0] rd_st, rd_sz;
  logic [31:0] rd_ty;
  logic [IdxW-1:0] rd_idx;
  logic fill_end;
  logic [CntW:0] ptr_off;
  mmos_out_t out_nxt;
  logic out_v_nxt;

  assign busy   = (state_r != ST_LOAD);
  assign accept = start && !busy;

  assign fill_end = (state_r == ST_FILL) && (ptr_r >= (CntW+1)'(cnt_r));
  assign ptr_off  = ptr_r - (CntW+1)'(cnt_r);
  assign rd_idx   = fill_end ? ptr_off[IdxW-1:0] : ptr_r[IdxW-1:0];
  assign rd_st  = st_mem[rd_idx];
  assign rd_sz  = sz_mem[rd_idx];
  assign rd_ty  = ty_mem[rd_idx];

  always_ff @(posedge clk) begin
    if (accept && cnt_r < CntW'(MaxEntries)) begin
      st_mem[cnt_r[IdxW-1:0]] <= in_data.entry_start;
      sz_mem[cnt_r[IdxW-1:0]] <= in_data.entry_size;
      ty_mem[cnt_r[IdxW-1:0]] <= in_data.entry_type;
    end
  end

  mmos_sorter u_sorter (
    .clk, .rst_n, .clr(srt_clr), .drain(srt_drain), .ins(srt_ins),
    .pt_in(srt_in), .head
  );

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; ovf_nxt = ovf_r; stat_nxt = stat_r;
    ptr_nxt = ptr_r; wait_nxt = wait_r; npts_nxt = npts_r; open_nxt = open_r;
    last_ty_nxt = last_ty_r; prev_addr_nxt = prev_addr_r; reg_st_nxt = reg_st_r;
    reg_ty_nxt = reg_ty_r; nreg_nxt = nreg_r; scan_nxt = scan_r; cur_nxt = cur_r;
    pend_st_nxt = pend_st_r; pend_sz_nxt = pend_sz_r; pend_ty_nxt = pend_ty_r;
    pt_nxt = pt_r; scanning_nxt = scanning_r;
    srt_clr = 1'b0; srt_drain = 1'b0; srt_ins = 1'b0; srt_in = '0;
    out_v_nxt = 1'b0; out_nxt = '0;
    out_nxt.overflowed = ovf_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (cnt_r < CntW'(MaxEntries)) cnt_nxt = cnt_r + 1'b1;
          else ovf_nxt = 1'b1;
          if (in_data.last_entry) begin
            state_nxt = ST_CHECK; ptr_nxt = '0; stat_nxt = STATUS_OK;
            srt_clr = 1'b1;
          end
        end
      end
      ST_CHECK: begin
        if (cnt_r < CntW'(2)) begin
          stat_nxt = STATUS_FEW; state_nxt = ST_RAW; ptr_nxt = '0;
        end else if (ptr_r == (CntW+1)'(cnt_r)) begin
          ptr_nxt = '0;
          state_nxt = (stat_r == STATUS_OK) ? ST_FILL : ST_RAW;
          npts_nxt = '0;
        end else begin
          if (rd_st + rd_sz < rd_st) stat_nxt = STATUS_WRAP;
          ptr_nxt = ptr_r + 1'b1;
        end
      end
      ST_RAW: begin
        if (cnt_r == '0) begin
          state_nxt = ST_EMPTY;
        end else begin
          out_v_nxt = 1'b1;
          out_nxt.region_start = rd_st; out_nxt.region_size = rd_sz;
          out_nxt.region_type = rd_ty; out_nxt.status = stat_r;
          out_nxt.last_region = (ptr_r + 1'b1 == (CntW+1)'(cnt_r));
          ptr_nxt = ptr_r + 1'b1;
          if (out_nxt.last_region) begin
            state_nxt = ST_LOAD; cnt_nxt = '0; ovf_nxt = 1'b0;
          end
        end
      end
      ST_FILL: begin
        // start points on the first pass over the entries, end points on the second
        if (ptr_r == (CntW+1)'(2 * cnt_r)) begin
          state_nxt = ST_DRAIN; wait_nxt = '0;
        end else begin
          ptr_nxt = ptr_r + 1'b1;
          if (rd_sz != '0) begin
            srt_ins = 1'b1; srt_in.vld = 1'b1;
            srt_in.is_end = fill_end;
            srt_in.idx = rd_idx;
            srt_in.addr = fill_end ? rd_st + rd_sz : rd_st;
            npts_nxt = npts_r + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        if (wait_r != SettleLast) begin
          wait_nxt = wait_r + 1'b1;
        end else begin
          state_nxt = ST_SWEEP; open_nxt = '0; last_ty_nxt = '0;
          prev_addr_nxt = '0; nreg_nxt = '0; scanning_nxt = 1'b0;
        end
      end
      ST_SWEEP: begin
        if (!scanning_r) begin
          if (npts_r == '0 || !head.vld) begin
            if (nreg_r == '0) begin
              state_nxt = ST_EMPTY;
            end else begin
              out_v_nxt = 1'b1;
              out_nxt.region_start = pend_st_r;
              out_nxt.region_size = pend_sz_r;
              out_nxt.region_type = pend_ty_r;
              out_nxt.status = STATUS_OK;
              out_nxt.last_region = 1'b1;
              state_nxt = ST_LOAD; cnt_nxt = '0; ovf_nxt = 1'b0;
            end
          end else begin
            pt_nxt = head; srt_drain = 1'b1; npts_nxt = npts_r - 1'b1;
            if (!head.is_end) open_nxt[head.idx] = 1'b1;
            else              open_nxt[head.idx] = 1'b0;
            scanning_nxt = 1'b1; scan_nxt = '0; cur_nxt = '0;
          end
        end else if (scan_r != (IdxW+1)'(MaxEntries)) begin
          if (open_r[scan_r[IdxW-1:0]] && ty_mem[scan_r[IdxW-1:0]] > cur_r)
            cur_nxt = ty_mem[scan_r[IdxW-1:0]];
          scan_nxt = scan_r + 1'b1;
        end else begin
          scanning_nxt = 1'b0;
          if (cur_r != last_ty_r) begin
            if (last_ty_r != '0 && pt_r.addr != prev_addr_r) begin
              // the held region goes out; the new one waits for a successor
              if (nreg_r != '0) begin
                out_v_nxt = 1'b1;
                out_nxt.region_start = pend_st_r;
                out_nxt.region_size = pend_sz_r;
                out_nxt.region_type = pend_ty_r;
                out_nxt.status = STATUS_OK;
              end
              pend_st_nxt = reg_st_r;
              pend_sz_nxt = pt_r.addr - prev_addr_r;
              pend_ty_nxt = reg_ty_r;
              nreg_nxt = nreg_r + 1'b1;
              if (nreg_nxt == CntW'(MaxEntries)) npts_nxt = '0;
            end
            if (cur_r != '0) begin
              reg_st_nxt = pt_r.addr; reg_ty_nxt = cur_r;
              prev_addr_nxt = pt_r.addr;
            end
            last_ty_nxt = cur_r;
          end
        end
      end
      ST_EMPTY: begin
        out_v_nxt = 1'b1; out_nxt.map_empty = 1'b1; out_nxt.status = stat_r;
        out_nxt.last_region = 1'b1;
        state_nxt = ST_LOAD; cnt_nxt = '0; ovf_nxt = 1'b0;
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD; cnt_r <= '0; ovf_r <= 1'b0; out_valid <= 1'b0;
      scanning_r <= 1'b0; ptr_r <= '0; wait_r <= '0; npts_r <= '0;
      open_r <= '0; nreg_r <= '0; stat_r <= STATUS_OK;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ovf_r <= ovf_nxt;
      out_valid <= out_v_nxt; scanning_r <= scanning_nxt; ptr_r <= ptr_nxt;
      wait_r <= wait_nxt; npts_r <= npts_nxt; open_r <= open_nxt;
      nreg_r <= nreg_nxt; stat_r <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data <= out_nxt; last_ty_r <= last_ty_nxt; prev_addr_r <= prev_addr_nxt;
    reg_st_r <= reg_st_nxt; reg_ty_r <= reg_ty_nxt; scan_r <= scan_nxt;
    cur_r <= cur_nxt; pt_r <= pt_nxt;
    pend_st_r <= pend_st_nxt; pend_sz_r <= pend_sz_nxt; pend_ty_r <= pend_ty_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxEntries)) else $error("entry count overrun");
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_nxt |-> busy) else $error("result while idle");
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.last_region |-> !busy) else $error("busy after last");
endmodule

// ===== src/mmos_cell.sv =====
// ---------------------------------------------------------------------------
// mmos_cell: one cell of the insertion sorter
// Keeps the smaller of the held and incoming point, hands the other onward.
// In drain mode the row shifts toward cell zero.
// ---------------------------------------------------------------------------
module mmos_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              clr,
  input  logic              ins,
  input  logic              drain,
  input  mmos_pkg::mmos_pt_t pass_in,
  input  mmos_pkg::mmos_pt_t drain_in,
  output mmos_pkg::mmos_pt_t pass_out,
  output mmos_pkg::mmos_pt_t held
);
  import mmos_pkg::*;

  mmos_pt_t held_r, held_nxt;

  always_comb begin
    held_nxt = held_r;
    pass_out = pass_in;
    if (clr) begin
      held_nxt = '0;
    end else if (drain) begin
      held_nxt = drain_in;
    end else if (ins) begin
      // stable: incoming goes before held only when strictly before
      if (pt_before(pass_in, held_r)) begin
        held_nxt = pass_in;
        pass_out = held_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) held_r <= '0;
    else        held_r <= held_nxt;
  end

  assign held = held_r;
endmodule

// ===== src/mmos_sorter.sv =====
// ---------------------------------------------------------------------------
// mmos_sorter: row of sort cells with one registered stage between cells
// A point enters per cycle; the head emerges at cell zero when draining.
// ---------------------------------------------------------------------------
module mmos_sorter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clr,
  input  logic               drain,
  input  logic               ins,
  input  mmos_pkg::mmos_pt_t pt_in,
  output mmos_pkg::mmos_pt_t head
);
  import mmos_pkg::*;

  mmos_pt_t pass_w [NumPts];
  mmos_pt_t link_r [NumPts];
  mmos_pt_t held_w [NumPts];

  for (genvar g = 0; g < NumPts; g++) begin : g_cell
    mmos_pt_t pin, din;
    logic     cin;
    if (g == 0) begin : g_head
      assign pin = pt_in;
      assign cin = ins;
    end else begin : g_link
      assign pin = link_r[g-1];
      assign cin = link_r[g-1].vld;
    end
    if (g == NumPts - 1) begin : g_tail
      assign din = '0;
    end else begin : g_next
      assign din = held_w[g+1];
    end
    mmos_cell u_cell (
      .clk, .rst_n, .clr, .drain,
      .ins      (cin),
      .pass_in  (pin),
      .drain_in (din),
      .pass_out (pass_w[g]),
      .held     (held_w[g])
    );
    always_ff @(posedge clk) begin
      if (!rst_n || clr || drain) link_r[g] <= '0;
      else if (g == 0 && !ins)     link_r[g] <= '0;
      else                         link_r[g] <= pass_w[g];
    end
  end

  assign head = held_w[0];
endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: testbench for memory_map_overlap_sanitizer
// Drives memory maps entry by entry, predicts the sanitized or unchanged
// region list for each closed map and checks every region transaction.
// ---------------------------------------------------------------------------
module tb_top;
  import mmos_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  mmos_in_t  in_data = '0;
  logic      out_valid;
  mmos_out_t out_data;

  memory_map_overlap_sanitizer dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always #2 clk = ~clk;

  localparam int IdleLimit = 20000;

  logic [63:0] map_start [MaxEntries];
  logic [63:0] map_size  [MaxEntries];
  logic [31:0] map_type  [MaxEntries];
  int          map_count;
  logic        map_over;
  mmos_out_t   region_queue[$];
  int          errors = 0;
  int          entries_sent = 0;
  int          regions_seen = 0;
  int          maps_closed = 0;
  int          idle_cycles = 0;

  task automatic report(input string what, input mmos_out_t got, input mmos_out_t exp);
    errors++;
    $display("mismatch %s: got %h exp %h", what, got, exp);
  endtask

  function automatic mmos_out_t mk_region(logic [63:0] st, logic [63:0] sz,
                                          logic [31:0] ty, logic [1:0] stat,
                                          logic empty);
    mmos_out_t r;
    r.region_start = st;
    r.region_size  = sz;
    r.region_type  = ty;
    r.status       = stat;
    r.map_empty    = empty;
    r.overflowed   = map_over;
    r.last_region  = 1'b0;
    return r;
  endfunction

  task automatic sweep_regions(ref mmos_out_t res[$]);
    logic [63:0] pa [2*MaxEntries];
    int          pt [2*MaxEntries];
    int          opn [MaxEntries];
    int          npts, nopen, j, idx, t;
    logic [63:0] a, addr, prev_addr, reg_start, sz;
    logic [31:0] prev_type, cur, reg_type;
    logic        bf;
    npts = 0; nopen = 0; prev_type = 0; prev_addr = 0; reg_start = 0; reg_type = 0;
    for (int i = 0; i < map_count; i++) begin
      if (map_size[i] != 0) begin
        pa[npts] = map_start[i]; pt[npts] = i * 2; npts++;
        pa[npts] = map_start[i] + map_size[i]; pt[npts] = i * 2 + 1; npts++;
      end
    end
    for (int i = 1; i < npts; i++) begin
      a = pa[i]; t = pt[i]; j = i;
      while (j > 0) begin
        bf = (a < pa[j-1]) || (a == pa[j-1] && t[0] == 0 && pt[j-1][0] == 1);
        if (!bf) break;
        pa[j] = pa[j-1]; pt[j] = pt[j-1]; j--;
      end
      pa[j] = a; pt[j] = t;
    end
    for (int i = 0; i < npts; i++) begin
      idx = pt[i] >> 1; addr = pa[i]; cur = 0;
      if (pt[i][0] == 0) begin
        if (nopen < MaxEntries) begin opn[nopen] = idx; nopen++; end
      end else begin
        for (int k = 0; k < nopen; k++) begin
          if (opn[k] == idx) begin opn[k] = opn[nopen-1]; nopen--; break; end
        end
      end
      for (int k = 0; k < nopen; k++)
        if (map_type[opn[k]] > cur) cur = map_type[opn[k]];
      if (cur != prev_type) begin
        if (prev_type != 0) begin
          sz = addr - prev_addr;
          if (sz != 0) begin
            res.push_back(mk_region(reg_start, sz, reg_type, STATUS_OK, 1'b0));
            if (res.size() >= MaxEntries) break;
          end
        end
        if (cur != 0) begin reg_start = addr; reg_type = cur; prev_addr = addr; end
        prev_type = cur;
      end
    end
  endtask

  task automatic predict_entry(input mmos_in_t e);
    mmos_out_t   res[$];
    logic [1:0]  stat;
    if (map_count < MaxEntries) begin
      map_start[map_count] = e.entry_start;
      map_size[map_count]  = e.entry_size;
      map_type[map_count]  = e.entry_type;
      map_count++;
    end else begin
      map_over = 1'b1;
    end
    if (!e.last_entry) return;
    stat = STATUS_OK;
    if (map_count < 2) stat = STATUS_FEW;
    else
      for (int i = 0; i < map_count; i++)
        if (map_start[i] + map_size[i] < map_start[i]) stat = STATUS_WRAP;
    if (stat == STATUS_OK) sweep_regions(res);
    else
      for (int i = 0; i < map_count; i++)
        res.push_back(mk_region(map_start[i], map_size[i], map_type[i], stat, 1'b0));
    if (res.size() == 0) res.push_back(mk_region(64'd0, 64'd0, 32'd0, stat, 1'b1));
    res[res.size()-1].last_region = 1'b1;
    foreach (res[i]) region_queue.push_back(res[i]);
    map_count = 0;
    map_over = 1'b0;
    maps_closed++;
  endtask

  // sender bursts: gap before a transaction at random
  int burst_left = 0;

  task automatic send_entry(input logic [63:0] st, input logic [63:0] sz,
                            input logic [31:0] ty, input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_data.entry_start <= st;
    in_data.entry_size  <= sz;
    in_data.entry_type  <= ty;
    in_data.last_entry  <= last;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    predict_entry({st, sz, ty, last});
    entries_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      regions_seen++;
      if (region_queue.size() == 0) begin
        report("unexpected", out_data, '0);
      end else begin
        mmos_out_t exp;
        exp = region_queue.pop_front();
        if (out_data.region_start !== exp.region_start) report("start", out_data, exp);
        if (out_data.region_size !== exp.region_size) report("size", out_data, exp);
        if (out_data.region_type !== exp.region_type) report("type", out_data, exp);
        if (out_data.status !== exp.status) report("status", out_data, exp);
        if (out_data.map_empty !== exp.map_empty) report("empty", out_data, exp);
        if (out_data.overflowed !== exp.overflowed) report("overflow", out_data, exp);
        if (out_data.last_region !== exp.last_region) report("last", out_data, exp);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IdleLimit) begin
      $display("watchdog timeout");
      $display("tb_top: errors");
      $finish;
    end
  end

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_few_entries();
    send_entry(64'h1000, 64'h2000, 32'd1, 1'b1);
    send_entry(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_wrap();
    send_entry(64'hFFFF_FFFF_FFFF_F000, 64'h2000, 32'd1, 1'b0);
    send_entry(64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 32'd2, 1'b0);
    send_entry(64'h100, 64'h0, 32'd3, 1'b1);
  endtask

  task automatic test_overlap();
    send_entry(64'h0, 64'h1000, 32'd1, 1'b0);
    send_entry(64'h800, 64'h1000, 32'd3, 1'b0);
    send_entry(64'h1800, 64'h800, 32'd2, 1'b0);
    send_entry(64'h1800, 64'h0, 32'd9, 1'b0);
    send_entry(64'h3000, 64'h100, 32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_empty_map();
    send_entry(64'h10, 64'h0, 32'd5, 1'b0);
    send_entry(64'h20, 64'h40, 32'd0, 1'b1);
  endtask

  task automatic test_overflow();
    for (int i = 0; i < MaxEntries + 2; i++)
      send_entry(64'(i) * 64'h100, 64'h80, 32'(i % 4), i == MaxEntries + 1);
  endtask

  task automatic test_random_maps();
    int n, sent;
    logic [63:0] st, sz;
    sent = 0;
    while (sent < 170) begin
      n = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 8);
      for (int i = 0; i < n; i++) begin
        case ($urandom_range(0, 9))
          0: begin st = rnd64(); sz = rnd64(); end
          1: begin st = $urandom_range(0, 64) * 64'h10; sz = 0; end
          default: begin
            st = $urandom_range(0, 64) * 64'h10;
            sz = $urandom_range(1, 32) * 64'h10;
          end
        endcase
        send_entry(st, sz, ($urandom_range(0, 5) == 0) ? $urandom() :
                   32'($urandom_range(0, 4)), i == n - 1);
        sent++;
      end
    end
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    test_few_entries();
    test_wrap();
    test_overlap();
    test_empty_map();
    test_overflow();
    test_random_maps();
    start <= 1'b0;
    while (region_queue.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    $display("sent %0d entries closing %0d maps, checked %0d regions",
             entries_sent, maps_closed, regions_seen);
    if (errors == 0 && region_queue.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

// ===== memory_map_overlap_sanitizer.f =====
src/mmos_pkg.sv
src/mmos_cell.sv
src/mmos_sorter.sv
src/memory_map_overlap_sanitizer.sv
test/tb_top.sv
